>>> sv/protobuf_wire_field_scanner_assert.svh
// ---------------------------------------------------------------------------
// Protobuf wire field scanner assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef PROTOBUF_WIRE_FIELD_SCANNER_ASSERT_SVH
`define PROTOBUF_WIRE_FIELD_SCANNER_ASSERT_SVH
`ifndef SYNTH
// checked only outside reset
`define PBWFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PBWFS_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PBWFS_ASSERT(label, prop, msg)
`define PBWFS_ASSERT_ANY(label, prop, msg)
`endif
`endif

>>> sv/pbwfs_pkg.sv
// ---------------------------------------------------------------------------
// pbwfs_pkg
// Request types and code constants shared by the protobuf field scanner.
// ---------------------------------------------------------------------------
package pbwfs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } pbwfs_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] field_id;
    logic [2:0]  wire_kind;
    logic [63:0] value;
    logic [1:0]  error_code;
  } pbwfs_out_t;

  // result kinds
  localparam logic [1:0] KIND_SCALAR  = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_VAR_LONG  = 2'd1;
  localparam logic [1:0] ERR_BAD_WIRE  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  // wire types
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIX64  = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_FIX32  = 3'd5;

  // index of the tenth varint byte, where only bit 0 counts
  localparam logic [3:0] VAR_LAST_IDX = 4'd9;
  localparam logic [3:0] FIX64_BYTES  = 4'd8;
  localparam logic [3:0] FIX32_BYTES  = 4'd4;

endpackage

>>> sv/protobuf_wire_field_scanner.sv
// ---------------------------------------------------------------------------
// protobuf_wire_field_scanner
// Streaming protobuf wire-format decoder, one encoded byte per request.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item): one buffer byte per request,
// end_of_buffer set on the last byte of a buffer.
// Result channel (out_valid / out_stall / out_item): at most one result per
// byte: a finished scalar field, a length header, a payload byte or an error.
// A byte accepted into the byte register is decoded there and its result is
// loaded into the result register, which drives out_item, once it can take it.
// Throughput is one byte per cycle: the byte register feeds the decode logic
// and the result register; a new byte is taken every cycle unless both hold
// a request while the receiver stalls.
// Reset (synchronous, rst_n low) empties both registers and returns the
// parser to expect a tag. While out_stall is high a held result stays, the
// input register takes one more byte if it is empty, then in_stall rises.
// After an error, bytes are dropped with no result until end_of_buffer.
// ---------------------------------------------------------------------------
module protobuf_wire_field_scanner import pbwfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  pbwfs_in_t  in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output pbwfs_out_t out_item
);

  logic       s1_valid_r, s1_valid_nxt;
  pbwfs_in_t  s1_item_r;
  logic       out_valid_r, out_valid_nxt;
  pbwfs_out_t out_item_r;
  logic       advance;
  logic       res_valid;
  pbwfs_out_t res_item;

  // decode the held byte whenever the result register can take its output
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = (advance && res_valid) ? 1'b1
                       : (out_stall ? out_valid_r : 1'b0);

  pbwfs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .in_item  (s1_item_r),
    .res_valid(res_valid),
    .res_item (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (advance && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> sv/pbwfs_core.sv
// ---------------------------------------------------------------------------
// pbwfs_core
// Parse state and per-byte decode: one request is consumed per step.
// ---------------------------------------------------------------------------
`include "protobuf_wire_field_scanner_assert.svh"

module pbwfs_core import pbwfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  pbwfs_in_t  in_item,
  output logic       res_valid,
  output pbwfs_out_t res_item
);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIX64   = 3'd2,
    PH_FIX32   = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  byte_count_r, byte_count_nxt;
  logic [31:0] field_r, field_nxt;
  logic [2:0]  wire_r, wire_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic        failed_r, failed_nxt;

  logic [7:0]  b;
  logic        eob;
  logic [6:0]  var_shamt;
  logic [63:0] var_acc;
  logic        var_more;
  logic        var_long;
  logic [63:0] fix_acc;
  logic [3:0]  fix_count;
  logic [3:0]  fix_limit;
  logic [63:0] remain_dec;
  logic [31:0] tag_field;
  logic [2:0]  tag_wire;
  logic        do_fail;
  logic [1:0]  fail_code;
  logic [31:0] fail_field;
  logic [2:0]  fail_wire;

  assign b   = in_item.data_byte;
  assign eob = in_item.end_of_buffer;

  // varint group: 7 * byte_count bit offset, tenth byte lands in bit 63
  assign var_shamt = 7'({byte_count_r, 3'b000}) - 7'(byte_count_r);
  assign var_acc   = (byte_count_r < VAR_LAST_IDX)
                   ? (acc_r | ({57'd0, b[6:0]} << var_shamt[5:0]))
                   : (acc_r | {b[0], 63'd0});
  assign var_more  = b[7];
  assign var_long  = b[7] && (byte_count_r >= VAR_LAST_IDX);

  // little-endian fixed bytes
  assign fix_acc   = acc_r | ({56'd0, b} << {byte_count_r[2:0], 3'b000});
  assign fix_count = byte_count_r + 4'd1;
  assign fix_limit = (phase_r == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES;

  assign remain_dec = remain_r - 64'd1;
  assign tag_field  = var_acc[34:3];
  assign tag_wire   = var_acc[2:0];

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    byte_count_nxt = byte_count_r;
    field_nxt      = field_r;
    wire_nxt       = wire_r;
    remain_nxt     = remain_r;
    failed_nxt     = failed_r;
    res_valid      = 1'b0;
    res_item       = '0;
    do_fail        = 1'b0;
    fail_code      = ERR_NONE;
    fail_field     = field_r;
    fail_wire      = wire_r;

    if (failed_r) begin
      // drop bytes until the buffer ends
      if (eob) begin
        phase_nxt      = PH_TAG;
        acc_nxt        = '0;
        byte_count_nxt = '0;
        remain_nxt     = '0;
        field_nxt      = '0;
        wire_nxt       = '0;
        failed_nxt     = 1'b0;
      end
    end else begin
      unique case (phase_r)
        PH_TAG: begin
          if (var_long) begin
            do_fail    = 1'b1;
            fail_code  = ERR_VAR_LONG;
            fail_field = '0;
            fail_wire  = '0;
          end else if (var_more) begin
            if (eob) begin
              do_fail    = 1'b1;
              fail_code  = ERR_TRUNCATED;
              fail_field = '0;
              fail_wire  = '0;
            end else begin
              acc_nxt        = var_acc;
              byte_count_nxt = byte_count_r + 4'd1;
            end
          end else begin
            field_nxt      = tag_field;
            wire_nxt       = tag_wire;
            acc_nxt        = '0;
            byte_count_nxt = '0;
            fail_field     = tag_field;
            fail_wire      = tag_wire;
            unique case (tag_wire)
              WIRE_VARINT: phase_nxt = PH_VARINT;
              WIRE_FIX64:  phase_nxt = PH_FIX64;
              WIRE_LEN:    phase_nxt = PH_LENGTH;
              WIRE_FIX32:  phase_nxt = PH_FIX32;
              default: begin
                do_fail   = 1'b1;
                fail_code = ERR_BAD_WIRE;
              end
            endcase
            if (!do_fail && eob) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end
          end
        end

        PH_VARINT, PH_LENGTH: begin
          if (var_long) begin
            do_fail   = 1'b1;
            fail_code = ERR_VAR_LONG;
          end else if (var_more) begin
            if (eob) begin
              do_fail   = 1'b1;
              fail_code = ERR_TRUNCATED;
            end else begin
              acc_nxt        = var_acc;
              byte_count_nxt = byte_count_r + 4'd1;
            end
          end else if (phase_r == PH_VARINT || var_acc == '0) begin
            // scalar done, or empty length-delimited field
            phase_nxt      = PH_TAG;
            acc_nxt        = '0;
            byte_count_nxt = '0;
            remain_nxt     = '0;
            res_valid      = 1'b1;
            res_item.kind  = (phase_r == PH_VARINT) ? KIND_SCALAR : KIND_HEADER;
            res_item.field_id  = field_r;
            res_item.wire_kind = wire_r;
            res_item.value     = var_acc;
          end else if (eob) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            phase_nxt      = PH_PAYLOAD;
            acc_nxt        = '0;
            byte_count_nxt = '0;
            remain_nxt     = var_acc;
            res_valid      = 1'b1;
            res_item.kind      = KIND_HEADER;
            res_item.field_id  = field_r;
            res_item.wire_kind = wire_r;
            res_item.value     = var_acc;
          end
        end

        PH_FIX64, PH_FIX32: begin
          if (fix_count >= fix_limit) begin
            phase_nxt      = PH_TAG;
            acc_nxt        = '0;
            byte_count_nxt = '0;
            remain_nxt     = '0;
            res_valid      = 1'b1;
            res_item.kind      = KIND_SCALAR;
            res_item.field_id  = field_r;
            res_item.wire_kind = wire_r;
            res_item.value     = fix_acc;
          end else if (eob) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            acc_nxt        = fix_acc;
            byte_count_nxt = fix_count;
          end
        end

        PH_PAYLOAD: begin
          if (remain_dec == '0) begin
            phase_nxt      = PH_TAG;
            acc_nxt        = '0;
            byte_count_nxt = '0;
            remain_nxt     = '0;
            res_valid      = 1'b1;
          end else if (eob) begin
            do_fail   = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            remain_nxt = remain_dec;
            res_valid  = 1'b1;
          end
          res_item.kind      = KIND_PAYLOAD;
          res_item.field_id  = field_r;
          res_item.wire_kind = wire_r;
          res_item.value     = {56'd0, b};
        end

        default: begin
          phase_nxt      = PH_TAG;
          acc_nxt        = '0;
          byte_count_nxt = '0;
          remain_nxt     = '0;
        end
      endcase

      if (do_fail) begin
        phase_nxt      = PH_TAG;
        acc_nxt        = '0;
        byte_count_nxt = '0;
        remain_nxt     = '0;
        failed_nxt     = !eob;
        res_valid      = 1'b1;
        res_item       = '0;
        res_item.kind       = KIND_ERROR;
        res_item.field_id   = fail_field;
        res_item.wire_kind  = fail_wire;
        res_item.error_code = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TAG;
      acc_r        <= '0;
      byte_count_r <= '0;
      field_r      <= '0;
      wire_r       <= '0;
      remain_r     <= '0;
      failed_r     <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      acc_r        <= acc_nxt;
      byte_count_r <= byte_count_nxt;
      field_r      <= field_nxt;
      wire_r       <= wire_nxt;
      remain_r     <= remain_nxt;
      failed_r     <= failed_nxt;
    end
  end

  `PBWFS_ASSERT_ANY(a_reset_idle, !rst_n |=> (!failed_r && phase_r == PH_TAG), "reset busy")
  `PBWFS_ASSERT(a_fail_idle, failed_r |-> (phase_r == PH_TAG && byte_count_r == 4'd0), "open")
  `PBWFS_ASSERT(a_count_range, byte_count_r <= VAR_LAST_IDX, "byte count out of range")
  `PBWFS_ASSERT(a_payload_left, phase_r == PH_PAYLOAD |-> remain_r != 64'd0, "payload empty")
  `PBWFS_ASSERT(a_err_clean, (res_valid && res_item.kind == KIND_ERROR) |-> res_item.value == '0, "value")

endmodule
